/* design/cim_pkg.sv */
`default_nettype none

package cim_pkg;

	// Default sizes of the table.
	localparam int SLOTS_DEF      = 16;
	localparam int CARD_BYTES_DEF = 5;

	// Fixed field widths of the item ports.
	localparam int OP_W     = 3;
	localparam int SLOT_W   = 4;
	localparam int SERIAL_W = 40;
	localparam int ST_W     = 2;

	// Opcodes.
	localparam logic [OP_W-1:0] OP_STORE      = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND_EMPTY = 3'd3;
	localparam logic [OP_W-1:0] OP_REINIT     = 3'd4;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_OCCUPIED = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE     = 2'd2;

	// A first byte of this value marks a free slot.
	localparam logic [7:0] EMPTY_BYTE = 8'hFF;

	// Preset card held in slot 0 after reset, first byte in the top bits.
	localparam int PRESET_LEN = 5;
	localparam logic [8*PRESET_LEN-1:0] PRESET_CARD = {8'd67, 8'd4, 8'd23, 8'd20, 8'd68};

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [SLOT_W-1:0]   slot;
		logic [SERIAL_W-1:0] serial;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SLOT_W-1:0] found_slot;
	} rsp_t;

	// Item as it travels down the row of cells, with its answer so far.
	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [SLOT_W-1:0]   slot;
		logic [SERIAL_W-1:0] serial;
		logic [ST_W-1:0]     status;
		logic [SLOT_W-1:0]   found_slot;
	} token_t;

	// Reset contents of one slot, right-aligned in 64 bits. Bytes beyond the
	// preset are 0xFF; a short entry keeps only the first bytes of the preset.
	function automatic logic [63:0] reset_entry(int index, int card_bytes);
		logic [63:0] v;
		logic [7:0]  b;
		v = '0;
		if (index != 0) begin
			v = '1;
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (i < card_bytes) begin
					if (i < PRESET_LEN) begin
						b = PRESET_CARD[(PRESET_LEN - 1 - i) * 8 +: 8];
					end else begin
						b = EMPTY_BYTE;
					end
					v = {v[55:0], b};
				end
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/cim_cell.sv */
`default_nettype none

module cim_cell import cim_pkg::*; #(
	parameter int CARD_BYTES = CARD_BYTES_DEF,
	parameter int INDEX      = 0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire token_t in_tok,
	output logic        out_valid,
	output token_t      out_tok
);

	localparam int CARD_W = 8 * CARD_BYTES;
	localparam logic [CARD_W-1:0] RESET_VAL = CARD_W'(reset_entry(INDEX, CARD_BYTES));
	localparam logic [8:0] IDX = 9'(INDEX);
	localparam logic [SLOT_W-1:0] FOUND_IDX = IDX[SLOT_W-1:0];

	logic [CARD_W-1:0] entry_q;
	logic [CARD_W-1:0] entry_d;
	logic [CARD_W-1:0] key;
	logic [63:0]       serial_ext;
	logic              slot_hit;
	logic              valid_q;
	token_t            tok_d;
	token_t            tok_q;

	// The item names this cell when its slot field equals the cell's index.
	assign slot_hit   = ({{(9 - SLOT_W){1'b0}}, in_tok.slot} == IDX);
	assign serial_ext = 64'(in_tok.serial);

	// Act on the passing item and update the held entry.
	always_comb begin
		entry_d = entry_q;
		tok_d   = in_tok;
		key     = (in_tok.opcode == OP_LOOKUP) ? serial_ext[CARD_W-1:0] : '1;
		if (in_valid) begin
			case (in_tok.opcode) inside
				OP_STORE: begin
					if (slot_hit && entry_q[CARD_W-1 -: 8] == EMPTY_BYTE) begin
						entry_d      = serial_ext[CARD_W-1:0];
						tok_d.status = ST_OK;
					end
				end
				OP_DELETE: begin
					if (slot_hit) begin
						entry_d = '1;
					end
				end
				OP_LOOKUP, OP_FIND_EMPTY: begin
					// Only the first equal cell answers; later cells see it found.
					if (in_tok.status == ST_NONE && entry_q == key) begin
						tok_d.status     = ST_OK;
						tok_d.found_slot = FOUND_IDX;
					end
				end
				OP_REINIT: begin
					entry_d = RESET_VAL;
				end
				default: begin
				end
			endcase
		end
	end

	// Held entry and valid flag of the handed-on item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= RESET_VAL;
			valid_q <= 1'b0;
		end else begin
			entry_q <= entry_d;
			valid_q <= in_valid;
		end
	end

	// The item moves on to the next cell every cycle.
	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	assign out_valid = valid_q;
	assign out_tok   = tok_q;

endmodule

`default_nettype wire

/* design/card_id_match_table.sv */
// Card serial table: a row of SLOTS cells, one per slot, each holding its entry.
// Each item passes through the cells in slot order, one cell per cycle, then the result register.
// Only one item is in flight at a time; cmd_stall stays
// high from an accepted item until its result is taken.
// Reset: asynchronous, active low; every slot reads all ones except slot 0,
// which holds the preset card. No clearing pass is needed.
`default_nettype none

module card_id_match_table import cim_pkg::*; #(
	parameter int SLOTS      = SLOTS_DEF,
	parameter int CARD_BYTES = CARD_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	token_t           tok [SLOTS+1];
	logic [SLOTS:0]   tok_valid;
	logic             cmd_acc;
	logic             rsp_acc;
	logic             busy_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [ST_W-1:0]  start_status;

	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_acc   = rsp_valid_q && !rsp_stall;
	assign cmd_stall = busy_q;

	// Answer an item carries before any cell has acted on it.
	always_comb begin
		case (cmd.opcode) inside
			OP_STORE:                 start_status = ST_OCCUPIED;
			OP_LOOKUP, OP_FIND_EMPTY: start_status = ST_NONE;
			default:                  start_status = ST_OK;
		endcase
	end

	// The accepted item enters the first cell directly.
	always_comb begin
		tok[0].opcode     = cmd.opcode;
		tok[0].slot       = cmd.slot;
		tok[0].serial     = cmd.serial;
		tok[0].status     = start_status;
		tok[0].found_slot = '0;
	end
	assign tok_valid[0] = cmd_acc;

	// Row of cells.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cim_cell #(
			.CARD_BYTES (CARD_BYTES),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (tok_valid[i]),
			.in_tok    (tok[i]),
			.out_valid (tok_valid[i+1]),
			.out_tok   (tok[i+1])
		);
	end

	// Busy flag and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				busy_q <= 1'b1;
			end else if (rsp_acc) begin
				busy_q <= 1'b0;
			end
			if (tok_valid[SLOTS]) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result register, loaded as the item leaves the last cell.
	always_ff @(posedge clk) begin
		if (tok_valid[SLOTS]) begin
			rsp_q.status     <= tok[SLOTS].status;
			rsp_q.found_slot <= tok[SLOTS].found_slot;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* design/cim_checker.sv */
`default_nettype none

module cim_checker import cim_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_stall,
	input wire cmd_t cmd,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Only one item is in flight: an accepted item closes the input.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("item accepted while another is in flight");

	// The input stays closed while a result waits.
	a_busy_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cmd_stall)
		else $error("input open while a result waits");

	// A result never arrives in the cycle after its item was accepted.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> !rsp_valid)
		else $error("result appeared too early");

	// A miss carries slot zero, and the status is a defined code.
	a_rsp_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_OCCUPIED ||
			(rsp.status == ST_NONE && rsp.found_slot == '0)))
		else $error("bad result code");

endmodule

bind card_id_match_table cim_checker u_cim_checker (.*);

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
	import cim_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CARD_W     = 8 * CARD_BYTES_DEF;
	localparam int POOL_N     = 8;
	localparam int HOLD_LEN   = 400;
	localparam int CYCLE_CAP  = 1000000;
	localparam int PHASE_LEN  = 390;
	localparam int DRAIN_WAIT = SLOTS_DEF + 4;

	// Opcodes that the block treats as no operation.
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Own copy of the serial table, and the answers still owed by the block.
	logic [CARD_W-1:0] card_copy [SLOTS_DEF];
	rsp_t              rsp_due [$];
	logic [CARD_W-1:0] serial_pool [POOL_N];

	int  send_idle_pct = 0;
	int  rsp_stall_pct = 0;
	logic hold_on      = 1'b0;
	int  errors        = 0;
	int  items_sent    = 0;
	int  results_seen  = 0;
	int  cycle_cnt     = 0;

	card_id_match_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Run guard: a hung block ends the run here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_CAP) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_cnt);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Table contents after reset or reinitialisation.
	function automatic void table_restore();
		for (int i = 0; i < SLOTS_DEF; i++) begin
			card_copy[i] = '1;
		end
		card_copy[0] = PRESET_CARD;
	endfunction

	// Applies one command to the table copy and returns the answer it earns.
	function automatic rsp_t table_apply(input cmd_t c);
		rsp_t              r;
		logic [CARD_W-1:0] key;
		logic              hit;
		int                idx;
		r   = '0;
		hit = 1'b0;
		idx = 0;
		case (c.opcode)
			OP_STORE: begin
				if (card_copy[c.slot][CARD_W-1 -: 8] == EMPTY_BYTE) begin
					card_copy[c.slot] = c.serial[CARD_W-1:0];
				end else begin
					r.status = ST_OCCUPIED;
				end
			end
			OP_DELETE: begin
				card_copy[c.slot] = '1;
			end
			OP_LOOKUP, OP_FIND_EMPTY: begin
				key = (c.opcode == OP_LOOKUP) ? c.serial[CARD_W-1:0] : '1;
				// Walk downwards so that the lowest matching slot wins.
				for (int i = SLOTS_DEF - 1; i >= 0; i--) begin
					if (card_copy[i] == key) begin
						hit = 1'b1;
						idx = i;
					end
				end
				if (hit) begin
					r.found_slot = idx[SLOT_W-1:0];
				end else begin
					r.status = ST_NONE;
				end
			end
			OP_REINIT: begin
				table_restore();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic cmd_t make_cmd(input logic [OP_W-1:0] op, input int slot,
			input logic [SERIAL_W-1:0] serial);
		cmd_t c;
		c.opcode = op;
		c.slot   = slot[SLOT_W-1:0];
		c.serial = serial;
		return c;
	endfunction

	function automatic logic [SERIAL_W-1:0] rand_serial();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[SERIAL_W-1:0];
	endfunction

	// Random command: mostly table traffic on a small pool of serials so that
	// lookups hit, with random serials, reinitialisation and spare opcodes mixed in.
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   r;
		int   spare;
		r      = $urandom_range(99);
		spare  = $urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST);
		c.slot = SLOT_W'($urandom_range(SLOTS_DEF - 1));
		if ($urandom_range(99) < 65) begin
			c.serial = serial_pool[3'($urandom_range(POOL_N - 1))];
		end else begin
			c.serial = rand_serial();
		end
		if (r < 30) begin
			c.opcode = OP_STORE;
		end else if (r < 48) begin
			c.opcode = OP_DELETE;
		end else if (r < 72) begin
			c.opcode = OP_LOOKUP;
		end else if (r < 84) begin
			c.opcode = OP_FIND_EMPTY;
		end else if (r < 88) begin
			c.opcode = OP_REINIT;
		end else if (r < 92) begin
			c.opcode = spare[OP_W-1:0];
		end else begin
			c.opcode = OP_LOOKUP;
			c.serial = rand_serial();
		end
		return c;
	endfunction

	// Offers one item, waits for it to be taken, and records its answer.
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do begin
			@(posedge clk);
		end while (cmd_stall);
		rsp_due.push_back(table_apply(c));
		items_sent++;
	endtask

	// Stops offering and waits until every answer has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (rsp_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t want;
		results_seen++;
		if (rsp_due.size() == 0) begin
			$display("%0t: unexpected result item: status %0d found_slot %0d",
				$time, got.status, got.found_slot);
			errors++;
		end else begin
			want = rsp_due.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.found_slot !== want.found_slot) begin
				$display("%0t: found_slot mismatch: expected %0d, actual %0d",
					$time, want.found_slot, got.found_slot);
				errors++;
			end
		end
	endtask

	// Result side: random stall, the long hold-off, and the check of each item.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			check_rsp(rsp);
		end
		rsp_stall <= hold_on || ($urandom_range(99) < rsp_stall_pct);
	end

	// Every opcode, both ends of each field, and the awkward table cases.
	task automatic test_directed();
		logic [SERIAL_W-1:0] key;
		key = 40'h12_3456_789A;
		send_cmd(make_cmd(OP_LOOKUP, 0, PRESET_CARD));
		send_cmd(make_cmd(OP_FIND_EMPTY, 0, '0));
		send_cmd(make_cmd(OP_STORE, 0, key));
		send_cmd(make_cmd(OP_STORE, SLOTS_DEF - 1, '0));
		send_cmd(make_cmd(OP_LOOKUP, 3, '0));
		// An all-ones store leaves the slot looking empty.
		send_cmd(make_cmd(OP_STORE, 1, '1));
		send_cmd(make_cmd(OP_LOOKUP, 0, '1));
		// A first byte of 0xFF marks the slot free for store, but not for find-empty.
		send_cmd(make_cmd(OP_STORE, 2, 40'hFF_0000_0000));
		send_cmd(make_cmd(OP_FIND_EMPTY, 9, key));
		send_cmd(make_cmd(OP_STORE, 2, key));
		send_cmd(make_cmd(OP_LOOKUP, 0, key));
		send_cmd(make_cmd(OP_DELETE, 0, '1));
		send_cmd(make_cmd(OP_LOOKUP, 0, PRESET_CARD));
		send_cmd(make_cmd(OP_STORE, 0, 40'h7F_FFFF_FFFF));
		send_cmd(make_cmd(OP_DELETE, SLOTS_DEF - 1, '0));
		send_cmd(make_cmd(OP_LOOKUP, 0, '0));
		send_cmd(make_cmd(OP_SPARE_FIRST, SLOTS_DEF - 1, '1));
		send_cmd(make_cmd(OP_SPARE_MID, 0, '0));
		send_cmd(make_cmd(OP_SPARE_LAST, 5, key));
		send_cmd(make_cmd(OP_DELETE, 7, key));
		send_cmd(make_cmd(OP_REINIT, SLOTS_DEF - 1, '1));
		send_cmd(make_cmd(OP_LOOKUP, 0, PRESET_CARD));
		send_cmd(make_cmd(OP_LOOKUP, 0, 40'h7F_FFFF_FFFF));
		send_cmd(make_cmd(OP_FIND_EMPTY, 0, '0));
		drain();
	endtask

	// Fills every slot so that find-empty and the all-ones lookup find nothing.
	task automatic test_full_table();
		logic [SERIAL_W-1:0] last;
		last = '0;
		send_cmd(make_cmd(OP_REINIT, 0, '0));
		for (int s = 1; s < SLOTS_DEF; s++) begin
			last = rand_serial();
			last[SERIAL_W-1] = 1'b0;
			send_cmd(make_cmd(OP_STORE, s, last));
		end
		send_cmd(make_cmd(OP_FIND_EMPTY, 0, '0));
		send_cmd(make_cmd(OP_LOOKUP, 0, '1));
		send_cmd(make_cmd(OP_LOOKUP, 0, last));
		send_cmd(make_cmd(OP_STORE, SLOTS_DEF - 1, '0));
		send_cmd(make_cmd(OP_REINIT, 0, '0));
		drain();
	endtask

	// The result side holds off for a long stretch while items keep coming.
	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				hold_on <= 1'b0;
			end
			begin
				for (int n = 0; n < 8; n++) begin
					send_cmd(rand_cmd());
				end
			end
		join
		drain();
	endtask

	task automatic test_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			send_cmd(rand_cmd());
		end
		drain();
	endtask

	initial begin
		table_restore();
		serial_pool[0] = PRESET_CARD;
		serial_pool[1] = '1;
		for (int i = 2; i < POOL_N; i++) begin
			serial_pool[i] = rand_serial();
		end
		// Two pool entries start with 0xFF but are not empty.
		serial_pool[POOL_N - 1][CARD_W-1 -: 8] = EMPTY_BYTE;
		serial_pool[POOL_N - 2][CARD_W-1 -: 8] = EMPTY_BYTE;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_backpressure();
		test_random(PHASE_LEN, 0, 0);
		test_random(PHASE_LEN, 74, 0);
		test_random(PHASE_LEN, 0, 74);
		test_random(PHASE_LEN, 16, 16);

		$display("Sent %0d items covering every opcode, a full table and a long hold-off;",
			items_sent);
		$display("checked %0d result items under four idle and stall mixes, %0d errors.",
			results_seen, errors);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* card_id_match_table.f */
design/cim_pkg.sv
design/cim_cell.sv
design/card_id_match_table.sv
design/cim_checker.sv
dv/tb.sv
